// ===== hdl/gss_pkg.sv =====
// Shared types, constants and tables for the golden-section minimum search.
`timescale 1ns / 1ps

package gss_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRACTION_BITS = 24;

    // Shift that takes 10*|x| from the input format to a Q30 angle.
    localparam int ANG_SHIFT = 30 - FRACTION_BITS;
    // |x| <= 2^31, times 10 < 2^35, then shifted into Q30.
    localparam int ANG_W     = 36 + ANG_SHIFT;
    // 2*pi in Q30 is at least 2^32, so the quotient has at most ANG_W-32 bits.
    localparam int MOD_STEPS = ANG_W - 32;
    localparam int CNT_W     = 5;

    localparam logic [31:0]        GOLD_R      = 32'h9E3779B9;
    localparam logic [ANG_W-1:0]   TWO_PI_ANG  = ANG_W'(64'd6746518852);
    localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);
    localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STAGES - 1);

    typedef enum logic [1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_ITER_LIMIT = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_PROBE,
        ST_LOAD,
        ST_MOD,
        ST_FOLD,
        ST_ROT,
        ST_PROD,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             probe;
        logic             eval_load;
        logic             probe_sel;
        logic             mod_step;
        logic             fold;
        logic             rot_step;
        logic             prod;
        logic             save_up;
        logic             update;
        logic             emit;
        logic             limit_flag;
        logic [CNT_W-1:0] step_idx;
    } gss_cmd_t;

    typedef struct packed {
        logic wide;
        logic at_limit;
    } gss_status_t;

    function automatic logic [31:0] atan_at(input logic [CNT_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/gss_datapath.sv =====
// Interval registers, probe arithmetic, angle reduction, CORDIC and result register.
`timescale 1ns / 1ps

module gss_datapath
    import gss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  gss_cmd_t           cmd,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic [30:0]        tol,
    input  logic [7:0]         limit,
    output gss_status_t        status,
    output logic signed [31:0] minimum_position,
    output logic               limit_reached
);

    logic signed [31:0]    lo_reg, hi_reg, up_reg, dn_reg, pos_reg;
    logic [31:0]           d_reg, ax_reg;
    logic [7:0]            step_count_reg;
    logic [ANG_W-1:0]      ang_reg;
    logic signed [33:0]    z_reg, cx_reg, cy_reg;
    logic signed [64:0]    p_reg, p_up_reg;
    logic                  lim_reg;

    logic signed [33:0]    wid;
    logic [63:0]           dprod;
    logic signed [31:0]    x_sel;
    logic [31:0]           ax_next;
    logic [ANG_W:0]        sub_val;
    logic signed [33:0]    z0, z1, z_fold;
    logic signed [33:0]    sx, sy, at;
    logic signed [32:0]    mid_sum;

    assign wid = 34'(hi_reg) - 34'(lo_reg);
    assign status.wide = !wid[33] && (wid[32:0] > {2'b00, tol});
    assign status.at_limit = step_count_reg >= limit;

    assign dprod = 64'(wid[31:0]) * 64'(GOLD_R);

    assign x_sel   = cmd.probe_sel ? dn_reg : up_reg;
    assign ax_next = x_sel[31] ? (~x_sel + 32'd1) : x_sel;

    assign sub_val = (ANG_W + 1)'(TWO_PI_ANG) << cmd.step_idx;

    // Reduce to [-pi, pi], then fold into [-pi/2, pi/2] with sin(pi - a) = sin(a).
    assign z0 = {1'b0, ang_reg[32:0]};
    assign z1 = (z0 > PI_Q30) ? (z0 - TWO_PI_Q30) : z0;
    always_comb
    begin
        if (z1 > HALF_PI_Q30)
            z_fold = PI_Q30 - z1;
        else if (z1 < -HALF_PI_Q30)
            z_fold = -PI_Q30 - z1;
        else
            z_fold = z1;
    end

    assign sx = cx_reg >>> cmd.step_idx;
    assign sy = cy_reg >>> cmd.step_idx;
    assign at = signed'(34'(atan_at(cmd.step_idx)));

    assign mid_sum = 33'(lo_reg) + 33'(hi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg <= lower_bound;
            hi_reg <= upper_bound;
        end
        if (cmd.mul)
            d_reg <= dprod[63:32];
        if (cmd.probe)
        begin
            up_reg <= lo_reg + signed'(d_reg);
            dn_reg <= hi_reg - signed'(d_reg);
        end
        if (cmd.eval_load)
        begin
            ax_reg  <= ax_next;
            ang_reg <= (ANG_W'(ax_next) * ANG_W'(10)) << ANG_SHIFT;
        end
        if (cmd.mod_step && ({1'b0, ang_reg} >= sub_val))
            ang_reg <= ang_reg - sub_val[ANG_W-1:0];
        if (cmd.fold)
        begin
            z_reg  <= z_fold;
            cx_reg <= GAIN_Q30;
            cy_reg <= '0;
        end
        if (cmd.rot_step)
        begin
            if (!z_reg[33])
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                z_reg  <= z_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                z_reg  <= z_reg + at;
            end
        end
        if (cmd.prod)
            p_reg <= signed'({1'b0, ax_reg}) * signed'(cy_reg[31:0]);
        if (cmd.save_up)
            p_up_reg <= p_reg;
        // f = -p, so f(up) < f(dn) means p(up) > p(dn).
        if (cmd.update)
        begin
            if (p_up_reg > p_reg)
                lo_reg <= dn_reg;
            else
                hi_reg <= up_reg;
        end
        if (cmd.emit)
        begin
            pos_reg <= mid_sum[32:1];
            lim_reg <= cmd.limit_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_count_reg <= '0;
        else if (cmd.load)
            step_count_reg <= '0;
        else if (cmd.update)
            step_count_reg <= step_count_reg + 8'd1;
    end

    assign minimum_position = pos_reg;
    assign limit_reached    = lim_reg;

endmodule

// ===== hdl/gss_control.sv =====
// Sequencer for the narrowing steps and the two objective evaluations per step.
`timescale 1ns / 1ps

module gss_control
    import gss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  gss_status_t status,
    output gss_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;
    logic             lim_reg, lim_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            lim_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            lim_reg       <= lim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.probe_sel  = sel_reg;
        cmd.step_idx   = cnt_reg;
        cmd.limit_flag = lim_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.wide)
                begin
                    lim_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (status.at_limit)
                begin
                    lim_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe  = 1'b1;
                sel_next   = 1'b0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.eval_load = 1'b1;
                cnt_next      = MOD_LAST;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                // Restoring reduction, highest multiple of 2*pi first.
                cmd.mod_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FOLD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (cnt_reg == ROT_LAST)
                    state_next = ST_PROD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_PROD:
            begin
                cmd.prod = 1'b1;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // The upper-probe product is kept while the lower probe is loaded.
        if (state_reg == ST_LOAD && sel_reg)
            cmd.save_up = 1'b1;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/golden_section_minimum_search_top.sv =====
// Top level: configuration registers and the controller/datapath pair.
//
// Usage: one request on the input channel (lower_bound, upper_bound, signed
// Q8.24) yields one result on the output channel: minimum_position, the floor
// of the final interval's midpoint, and limit_reached, set when the step limit
// ended the search while the width still exceeded the tolerance.
// A transaction completes on a clock edge with valid high and stall low.
// Each narrowing step runs the serial angle reduction and then the single
// CORDIC unit, once for each of the two probes.
// One request is worked at a time; in_stall is high from acceptance until the
// result is written to the output register.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 tolerance, 1 iteration
// limit) and cfg_data; cfg_ready is always high. Write only while idle.
// Reset returns tolerance 17 and iteration limit 64 and clears out_valid.
// A stalled result holds; the next request may be accepted meanwhile and then
// waits for the output register to free.
`timescale 1ns / 1ps

module golden_section_minimum_search_top
    import gss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] minimum_position,
    output logic               limit_reached
);

    logic [30:0]  tol_reg;
    logic [7:0]   limit_reg;
    gss_cmd_t     cmd;
    gss_status_t  status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= 31'd17;
            limit_reg <= 8'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOLERANCE:  tol_reg   <= cfg_data[30:0];
                CFG_ITER_LIMIT: limit_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    gss_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .lower_bound      (lower_bound),
        .upper_bound      (upper_bound),
        .tol              (tol_reg),
        .limit            (limit_reg),
        .status           (status),
        .minimum_position (minimum_position),
        .limit_reached    (limit_reached)
    );

endmodule

// ===== hdl/gss_checker.sv =====
// Port-level assertions for the search block and their binding.
`timescale 1ns / 1ps

module gss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] minimum_position,
    input logic        limit_reached
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(minimum_position)
            && $stable(limit_reached))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting a request");

    a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("request finished without a result");

endmodule

bind golden_section_minimum_search_top gss_checker u_gss_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .minimum_position (minimum_position),
    .limit_reached    (limit_reached)
);
